/* rtl/dkop_pkg.sv */
// Shared types, widths, register codes and reset values for the double
// knock-out barrier payoff averager. No dependencies.
`default_nettype none

package dkop_pkg;

    localparam int PRICE_BITS      = 32;
    localparam int PATH_COUNT_BITS = 20;
    localparam int STEP_BITS       = 16;
    localparam int SUM_BITS        = PRICE_BITS + PATH_COUNT_BITS;
    localparam int CFG_DATA_BITS   = 32;
    localparam int CFG_IDX_BITS    = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

    localparam logic [PRICE_BITS-1:0]      LOWER_RESET  = PRICE_BITS'(5242880);
    localparam logic [PRICE_BITS-1:0]      UPPER_RESET  = PRICE_BITS'(9830400);
    localparam logic [PRICE_BITS-1:0]      STRIKE_RESET = PRICE_BITS'(6684672);
    localparam logic [STEP_BITS-1:0]       STEPS_RESET  = STEP_BITS'(400);
    localparam logic [PATH_COUNT_BITS-1:0] PATHS_RESET  = PATH_COUNT_BITS'(10000);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LOWER_BARRIER   = 3'd0,
        REG_UPPER_BARRIER   = 3'd1,
        REG_STRIKE_PRICE    = 3'd2,
        REG_STEPS_PER_PATH  = 3'd3,
        REG_PATHS_PER_BATCH = 3'd4,
        REG_OPTION_KIND     = 3'd5
    } reg_index_t;

    typedef enum logic {
        KIND_CALL = 1'b0,
        KIND_PUT  = 1'b1
    } option_kind_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0]      lower_barrier;
        logic [PRICE_BITS-1:0]      upper_barrier;
        logic [PRICE_BITS-1:0]      strike_price;
        logic [STEP_BITS-1:0]       steps_per_path;
        logic [PATH_COUNT_BITS-1:0] paths_per_batch;
        option_kind_t               option_kind;
    } cfg_t;

    // One finished path on its way from the front end to the back end.
    typedef struct packed {
        logic                  knocked;
        logic [PRICE_BITS-1:0] last;
    } path_rec_t;

    typedef struct packed {
        logic                       start;
        logic [SUM_BITS-1:0]        dividend;
        logic [PATH_COUNT_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic [SUM_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/dkop_ifs.sv */
// Valid/ready channel interfaces: configuration writes, price samples and
// path results. Depends on dkop_pkg.
`default_nettype none

interface dkop_cfg_if
    import dkop_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface dkop_smp_if
    import dkop_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] price_sample;

    modport source (output valid, output price_sample, input ready);
    modport sink (input valid, input price_sample, output ready);
endinterface

interface dkop_res_if
    import dkop_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] path_payoff;
    logic                  batch_done;
    logic [PRICE_BITS-1:0] mean_payoff;

    modport source (output valid, output path_payoff, output batch_done,
                    output mean_payoff, input ready);
    modport sink (input valid, input path_payoff, input batch_done,
                  input mean_payoff, output ready);
endinterface

`default_nettype wire

/* rtl/dkop_front.sv */
// Front end: takes price samples, tracks knock-out and last kept price per
// path, pushes one record at each path end. Depends on dkop_pkg, dkop_ifs.
`default_nettype none

module dkop_front
    import dkop_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    dkop_smp_if.sink       smp,
    input  wire logic      q_full,
    output logic           q_push,
    output path_rec_t      q_data
);

    logic                  knocked_reg, knocked_next;
    logic [PRICE_BITS-1:0] last_reg, last_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;

    logic                  accept;
    logic                  ko;
    logic [PRICE_BITS-1:0] lp;
    logic [STEP_BITS-1:0]  step_inc;
    logic [STEP_BITS-1:0]  steps;
    logic                  path_end;

    assign smp.ready = !q_full;
    assign accept    = smp.valid && smp.ready;

    always_comb
    begin
        ko = knocked_reg;
        lp = last_reg;
        if (!knocked_reg)
        begin
            if (smp.price_sample > cfg.upper_barrier || smp.price_sample < cfg.lower_barrier)
                ko = 1'b1;
            else
                lp = smp.price_sample;
        end
        steps    = (cfg.steps_per_path == '0) ? STEP_BITS'(1) : cfg.steps_per_path;
        step_inc = step_reg + STEP_BITS'(1);
        path_end = (step_inc == '0) || (step_inc >= steps);

        knocked_next = knocked_reg;
        last_next    = last_reg;
        step_next    = step_reg;
        if (accept)
        begin
            if (path_end)
            begin
                knocked_next = 1'b0;
                last_next    = '0;
                step_next    = '0;
            end
            else
            begin
                knocked_next = ko;
                last_next    = lp;
                step_next    = step_inc;
            end
        end
    end

    assign q_push       = accept && path_end;
    assign q_data.knocked = ko;
    assign q_data.last    = lp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knocked_reg <= 1'b0;
            last_reg    <= '0;
            step_reg    <= '0;
        end
        else
        begin
            knocked_reg <= knocked_next;
            last_reg    <= last_next;
            step_reg    <= step_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/dkop_fifo.sv */
// Short path-record queue between front end and back end.
// Depends on dkop_pkg.
`default_nettype none

module dkop_fifo
    import dkop_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire path_rec_t wdata,
    input  wire logic      pop,
    output path_rec_t      rdata,
    output logic           full,
    output logic           empty
);

    path_rec_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wptr_reg, rptr_reg;
    logic [QPTR_BITS:0]    count_reg, count_next;

    assign full  = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPTR_BITS+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_BITS+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + QPTR_BITS'(1);
            if (pop)
                rptr_reg <= rptr_reg + QPTR_BITS'(1);
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("path queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("path queue read while empty");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (wptr_reg - rptr_reg) == count_reg[QPTR_BITS-1:0])
        else $error("path queue pointers disagree with fill count");
`endif

endmodule

`default_nettype wire

/* rtl/dkop_div.sv */
// Restoring divider for the batch mean, one quotient bit per cycle.
// Depends on dkop_pkg.
`default_nettype none

module dkop_div
    import dkop_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                       busy_reg;
    logic [DIV_CNT_BITS-1:0]    count_reg;
    logic [PATH_COUNT_BITS-1:0] rem_reg;
    logic [PATH_COUNT_BITS-1:0] divisor_reg;
    logic [SUM_BITS-1:0]        quot_reg;

    logic [PATH_COUNT_BITS:0]   shifted;
    logic [PATH_COUNT_BITS:0]   diff;
    logic                       ge;

    assign shifted = {rem_reg, quot_reg[SUM_BITS-1]};
    assign ge      = shifted >= {1'b0, divisor_reg};
    assign diff    = shifted - {1'b0, divisor_reg};

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= DIV_CNT_BITS'(SUM_BITS);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - DIV_CNT_BITS'(1);
            if (count_reg == DIV_CNT_BITS'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
            quot_reg    <= req.dividend;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_reg  <= ge ? diff[PATH_COUNT_BITS-1:0] : shifted[PATH_COUNT_BITS-1:0];
            quot_reg <= {quot_reg[SUM_BITS-2:0], ge};
        end
    end

endmodule

`default_nettype wire

/* rtl/dkop_back.sv */
// Back end: turns path records into payoffs, keeps the batch sum and path
// count, runs the mean division and owns the result register.
// Depends on dkop_pkg, dkop_ifs, dkop_div.
`default_nettype none

module dkop_back
    import dkop_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      q_empty,
    input  wire path_rec_t q_data,
    output logic           q_pop,
    dkop_res_if.source     res
);

    typedef enum logic {
        S_RUN,
        S_DIV
    } state_t;

    state_t                     state_reg, state_next;
    logic [SUM_BITS-1:0]        sum_reg, sum_next;
    logic [PATH_COUNT_BITS-1:0] path_reg, path_next;
    logic [PRICE_BITS-1:0]      held_reg, held_next;
    logic                       out_valid_reg, out_valid_next;
    logic [PRICE_BITS-1:0]      payoff_reg, payoff_next;
    logic                       done_reg, done_next;
    logic [PRICE_BITS-1:0]      mean_reg, mean_next;

    logic                       slot_free;
    logic [PRICE_BITS-1:0]      pay;
    logic [PATH_COUNT_BITS-1:0] paths;
    logic [PATH_COUNT_BITS-1:0] path_inc;
    logic [SUM_BITS-1:0]        sum_inc;
    logic                       batch_end;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    dkop_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign slot_free = !out_valid_reg || res.ready;
    assign q_pop     = (state_reg == S_RUN) && !q_empty && slot_free;

    always_comb
    begin
        if (q_data.knocked)
            pay = '0;
        else if (cfg.option_kind == KIND_CALL)
            pay = (q_data.last > cfg.strike_price) ? q_data.last - cfg.strike_price : '0;
        else
            pay = (cfg.strike_price > q_data.last) ? cfg.strike_price - q_data.last : '0;

        paths     = (cfg.paths_per_batch == '0) ? PATH_COUNT_BITS'(1) : cfg.paths_per_batch;
        path_inc  = path_reg + PATH_COUNT_BITS'(1);
        sum_inc   = sum_reg + SUM_BITS'(pay);
        batch_end = (path_inc == '0) || (path_inc >= paths);

        div_req.start    = 1'b0;
        div_req.dividend = sum_inc;
        div_req.divisor  = paths;

        state_next     = state_reg;
        sum_next       = sum_reg;
        path_next      = path_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !res.ready;
        payoff_next    = payoff_reg;
        done_next      = done_reg;
        mean_next      = mean_reg;

        case (state_reg)
            S_RUN:
            begin
                if (q_pop)
                begin
                    if (batch_end)
                    begin
                        // hold the payoff until the mean is ready
                        div_req.start = 1'b1;
                        held_next     = pay;
                        sum_next      = '0;
                        path_next     = '0;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        sum_next       = sum_inc;
                        path_next      = path_inc;
                        out_valid_next = 1'b1;
                        payoff_next    = pay;
                        done_next      = 1'b0;
                        mean_next      = '0;
                    end
                end
            end
            S_DIV:
            begin
                if (!div_rsp.busy && slot_free)
                begin
                    out_valid_next = 1'b1;
                    payoff_next    = held_reg;
                    done_next      = 1'b1;
                    mean_next      = div_rsp.quotient[PRICE_BITS-1:0];
                    state_next     = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    assign res.valid       = out_valid_reg;
    assign res.path_payoff = payoff_reg;
    assign res.batch_done  = done_reg;
    assign res.mean_payoff = mean_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            sum_reg       <= '0;
            path_reg      <= '0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            payoff_reg    <= '0;
            done_reg      <= 1'b0;
            mean_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            path_reg      <= path_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
            payoff_reg    <= payoff_next;
            done_reg      <= done_next;
            mean_reg      <= mean_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/double_knockout_payoff_average.sv */
// Top level of the double knock-out barrier payoff averager: configuration
// registers, front end, path queue and back end. Depends on dkop_pkg,
// dkop_ifs, dkop_front, dkop_fifo, dkop_back.
//
// Price samples (unsigned Q16.16) enter on samples, one per cycle unless the
// path queue is full. The front end checks each sample against both barriers
// and counts steps; at each path end it pushes one record into a 4-entry path
// queue. The back end takes one record per cycle while its result register
// is free and no division runs, forms the call or put payoff, adds it to the
// batch sum and presents one beat on results with the path payoff. The path
// that closes a batch also carries the mean, computed by a restoring divider
// that produces one quotient bit per cycle; the back end takes no other
// record while the division runs. The queue stalls samples at batch end only
// if it fills during the division. A stalled result register stalls the back
// end, and a full queue stalls samples. Configuration writes are always
// accepted; write them only while the block is idle. Writes to indexes past
// option_kind are ignored.
`default_nettype none

module double_knockout_payoff_average
    import dkop_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dkop_cfg_if.sink   cfg,
    dkop_smp_if.sink   samples,
    dkop_res_if.source results
);

    logic [PRICE_BITS-1:0]      lower_reg;
    logic [PRICE_BITS-1:0]      upper_reg;
    logic [PRICE_BITS-1:0]      strike_reg;
    logic [STEP_BITS-1:0]       steps_reg;
    logic [PATH_COUNT_BITS-1:0] paths_reg;
    option_kind_t               kind_reg;

    cfg_t      cfg_q;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    path_rec_t q_wdata;
    path_rec_t q_rdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg  <= LOWER_RESET;
            upper_reg  <= UPPER_RESET;
            strike_reg <= STRIKE_RESET;
            steps_reg  <= STEPS_RESET;
            paths_reg  <= PATHS_RESET;
            kind_reg   <= KIND_CALL;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (reg_index_t'(cfg.index))
                REG_LOWER_BARRIER:   lower_reg  <= cfg.data[PRICE_BITS-1:0];
                REG_UPPER_BARRIER:   upper_reg  <= cfg.data[PRICE_BITS-1:0];
                REG_STRIKE_PRICE:    strike_reg <= cfg.data[PRICE_BITS-1:0];
                REG_STEPS_PER_PATH:  steps_reg  <= cfg.data[STEP_BITS-1:0];
                REG_PATHS_PER_BATCH: paths_reg  <= cfg.data[PATH_COUNT_BITS-1:0];
                REG_OPTION_KIND:     kind_reg   <= option_kind_t'(cfg.data[0]);
                default:             ;
            endcase
        end
    end

    assign cfg_q.lower_barrier   = lower_reg;
    assign cfg_q.upper_barrier   = upper_reg;
    assign cfg_q.strike_price    = strike_reg;
    assign cfg_q.steps_per_path  = steps_reg;
    assign cfg_q.paths_per_batch = paths_reg;
    assign cfg_q.option_kind     = kind_reg;

    dkop_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_q),
        .smp    (samples),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    dkop_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    dkop_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_q),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .res     (results)
    );

endmodule

`default_nettype wire
